FILE: design/mat_sq_pkg.sv
package mat_sq_pkg;

	// field widths of the request and result items
	localparam int ELEM_W = 16;
	localparam int IDX_W  = 4;
	localparam int SIZE_W = 5;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int PV_W   = 36;

	// default matrix bound and register reset value
	localparam int MAX_DIM_DEF = 16;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd10;

	// request queue between front and back, power of two depth
	localparam int QUEUE_DEPTH = 2;

	// request modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// one queued request
	typedef struct packed {
		logic                     is_query;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [ELEM_W-1:0] value;
	} cmd_t;

endpackage

FILE: design/mat_sq_ram.sv
module mat_sq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    ra_addr,
	input  logic [AW-1:0]    rb_addr,
	output logic [WIDTH-1:0] ra_data,
	output logic [WIDTH-1:0] rb_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		ra_data <= mem_q[ra_addr];
		rb_data <= mem_q[rb_addr];
	end

endmodule

FILE: design/mat_sq_front.sv
module mat_sq_front #(
	parameter int MAX_DIM = mat_sq_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [mat_sq_pkg::IDX_W-1:0]        row,
	input  logic [mat_sq_pkg::IDX_W-1:0]        col,
	input  logic signed [mat_sq_pkg::ELEM_W-1:0] value,
	output logic                                cmd_valid,
	output mat_sq_pkg::cmd_t                    cmd,
	input  logic                                cmd_pop
);

	import mat_sq_pkg::*;

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           entry_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           accept;
	logic           in_store;
	logic           push;

	assign in_stall  = (cnt_q == QCW'(QUEUE_DEPTH));
	assign accept    = in_valid && !in_stall;

	// loads outside the store are taken and dropped here
	assign in_store  = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
	assign push      = accept && ((mode == MODE_QUERY) || in_store);

	assign cmd_valid = (cnt_q != '0);
	assign cmd       = entry_q[rd_ptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{is_query: (mode == MODE_QUERY), row: row, col: col,
			                       value: value};
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

endmodule

FILE: design/mat_sq_back.sv
module mat_sq_back #(
	parameter int MAX_DIM = mat_sq_pkg::MAX_DIM_DEF,
	parameter int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	input  mat_sq_pkg::cmd_t                     cmd,
	output logic                                 cmd_pop,
	input  logic [mat_sq_pkg::SIZE_W-1:0]        size_in_use,
	output logic                                 ram_we,
	output logic [AW-1:0]                        ram_waddr,
	output logic [mat_sq_pkg::ELEM_W-1:0]        ram_wdata,
	output logic [AW-1:0]                        ram_ra_addr,
	output logic [AW-1:0]                        ram_rb_addr,
	input  logic [mat_sq_pkg::ELEM_W-1:0]        ram_ra_data,
	input  logic [mat_sq_pkg::ELEM_W-1:0]        ram_rb_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mat_sq_pkg::PV_W-1:0]   product_value,
	output logic [mat_sq_pkg::IDX_W-1:0]         out_row,
	output logic [mat_sq_pkg::IDX_W-1:0]         out_col
);

	import mat_sq_pkg::*;

	localparam int KW    = $clog2(MAX_DIM + 1);
	localparam int ACC_W = (33 + $clog2(MAX_DIM) > PV_W) ? 33 + $clog2(MAX_DIM) : PV_W;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (PV_W - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd1 <<< (PV_W - 1)));

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]               state_q;
	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         col_q;
	logic                     row_ok_q;
	logic                     col_ok_q;
	logic [KW-1:0]            n_q;
	logic [KW-1:0]            k_q;
	logic [KW-1:0]            n_next;
	logic                     last_k;
	logic                     fin_q;
	logic                     v_s1;
	logic                     last_s1;
	logic                     v_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ELEM_W-1:0] a_op;
	logic signed [ELEM_W-1:0] b_op;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PV_W-1:0]   acc_sat;
	logic                     out_free;
	logic                     start_query;
	logic                     issue;
	logic                     finish;

	// size in use, bounded by the store
	assign n_next = (32'(size_in_use) > MAX_DIM) ? KW'(MAX_DIM) : KW'(size_in_use);
	assign last_k = ((k_q + KW'(1)) == n_q);

	assign cmd_pop     = (state_q == ST_IDLE) && cmd_valid;
	assign start_query = cmd_pop && cmd.is_query;
	assign issue       = (state_q == ST_RUN);
	assign out_free    = !out_valid || !out_stall;
	assign finish      = (state_q == ST_WAIT) && fin_q && out_free;

	// loads go straight to the store
	assign ram_we    = cmd_pop && !cmd.is_query;
	assign ram_waddr = AW'(cmd.row) * AW'(MAX_DIM) + AW'(cmd.col);
	assign ram_wdata = cmd.value;

	// row operand A[row][k] and column operand A[k][col]
	assign ram_ra_addr = row_ok_q ? AW'(row_q) * AW'(MAX_DIM) + AW'(k_q) : '0;
	assign ram_rb_addr = col_ok_q ? AW'(k_q) * AW'(MAX_DIM) + AW'(col_q) : '0;

	// entries outside the store count as zero
	assign a_op = row_ok_q ? $signed(ram_ra_data) : '0;
	assign b_op = col_ok_q ? $signed(ram_rb_data) : '0;

	// clamp to the result range
	always_comb begin
		if (acc_q > SAT_HI) begin
			acc_sat = PV_W'(SAT_HI);
		end else if (acc_q < SAT_LO) begin
			acc_sat = PV_W'(SAT_LO);
		end else begin
			acc_sat = acc_q[PV_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			case (state_q)
				ST_IDLE: begin
					if (start_query) begin
						fin_q   <= (n_next == '0);
						state_q <= (n_next == '0) ? ST_WAIT : ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_k) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (v_s2 && last_s2) begin
						fin_q <= 1'b1;
					end
					if (finish) begin
						fin_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query context and term index
	always_ff @(posedge clk) begin
		if (start_query) begin
			row_q    <= cmd.row;
			col_q    <= cmd.col;
			row_ok_q <= (32'(cmd.row) < MAX_DIM);
			col_ok_q <= (32'(cmd.col) < MAX_DIM);
			n_q      <= n_next;
			k_q      <= '0;
		end else if (issue) begin
			k_q <= k_q + KW'(1);
		end
	end

	// multiply and accumulate stages
	always_ff @(posedge clk) begin
		last_s1 <= issue && last_k;
		last_s2 <= last_s1;
		prod_s2 <= a_op * b_op;
		if (start_query) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			product_value <= acc_sat;
			out_row       <= row_q;
			out_col       <= col_q;
		end
	end

endmodule

FILE: design/matrix_square.sv
// A load goes from the queue into the store when the back end pops it; a query passes
// from the queue through issue, read, multiply, accumulate and the result register, or only the
// result register when the size is zero. Throughput: one load per cycle while the queue is not
// full; the back end takes one term per cycle and holds each query until its result is registered.
// Reset (arst_n low, asynchronous) empties the queue, drops any pending result and sets size_in_use
// to 10; the matrix store is not cleared and is undefined until written.
module matrix_square #(
	parameter int MAX_DIM = mat_sq_pkg::MAX_DIM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mat_sq_pkg::SIZE_W-1:0]        cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 mode,
	input  logic [mat_sq_pkg::IDX_W-1:0]         row,
	input  logic [mat_sq_pkg::IDX_W-1:0]         col,
	input  logic signed [mat_sq_pkg::ELEM_W-1:0] value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mat_sq_pkg::PV_W-1:0]   product_value,
	output logic [mat_sq_pkg::IDX_W-1:0]         out_row,
	output logic [mat_sq_pkg::IDX_W-1:0]         out_col
);

	import mat_sq_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;

	logic [SIZE_W-1:0] size_q;
	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_pop;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ELEM_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_ra_addr;
	logic [AW-1:0]     ram_rb_addr;
	logic [ELEM_W-1:0] ram_ra_data;
	logic [ELEM_W-1:0] ram_rb_data;

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// request intake and queue
	mat_sq_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.row       (row),
		.col       (col),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// execution of loads and queries
	mat_sq_back #(
		.MAX_DIM (MAX_DIM),
		.AW      (AW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.size_in_use   (size_q),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_ra_addr   (ram_ra_addr),
		.ram_rb_addr   (ram_rb_addr),
		.ram_ra_data   (ram_ra_data),
		.ram_rb_data   (ram_rb_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.product_value (product_value),
		.out_row       (out_row),
		.out_col       (out_col)
	);

	// matrix store
	mat_sq_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.ra_addr (ram_ra_addr),
		.rb_addr (ram_rb_addr),
		.ra_data (ram_ra_data),
		.rb_data (ram_rb_data)
	);

	// a full queue always has a request waiting for the back end
	a_stall_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> cmd_valid)
		else $error("queue full but no request visible");

	// the back end only pops a request that is there
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("pop from empty queue");

	// store writes come only from a popped load
	a_write_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cmd_pop && !cmd.is_query))
		else $error("store write without a load request");

endmodule

FILE: bench/matrix_square_tb.sv
`timescale 1ns / 1ps

module matrix_square_tb;
	import mat_sq_pkg::*;

	localparam int SETTLE_CYCLES = MAX_DIM_DEF + 16;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int PHASE_ITEMS   = 120;
	localparam int NUM_PHASES    = 6;

	// one expected element of the squared matrix
	typedef struct {
		logic signed [PV_W-1:0] product;
		logic [IDX_W-1:0]       row_idx;
		logic [IDX_W-1:0]       col_idx;
	} square_entry_t;

	// one row of the directed table: a request, or a new matrix size
	typedef enum logic [0:0] {STEP_REQ, STEP_SIZE} step_kind_t;

	typedef struct {
		step_kind_t             kind;
		logic                   op;
		logic [IDX_W-1:0]       r;
		logic [IDX_W-1:0]       c;
		logic signed [ELEM_W-1:0] v;
		bit                     typed;
		logic signed [PV_W-1:0] want;
	} dir_step_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [SIZE_W-1:0]        cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     mode = MODE_LOAD;
	logic [IDX_W-1:0]         row = '0;
	logic [IDX_W-1:0]         col = '0;
	logic signed [ELEM_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [PV_W-1:0]   product_value;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;

	// shadow copy of the store and the size register
	logic signed [ELEM_W-1:0] shadow_matrix [MAX_DIM_DEF][MAX_DIM_DEF];
	logic [SIZE_W-1:0]        size_model = SIZE_RESET;

	square_entry_t pending_squares [$];
	square_entry_t expected_entry;
	dir_step_t     directed_steps [$];

	bit no_idle = 1'b0;
	int stall_left = 0;
	int fail_count = 0;
	int results_checked = 0;
	int loads_sent = 0;
	int queries_sent = 0;
	int size_writes = 0;
	int cycle_count = 0;

	matrix_square u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.row           (row),
		.col           (col),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.product_value (product_value),
		.out_row       (out_row),
		.out_col       (out_col)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_squares.size());
			$display("status: fail");
			$finish;
		end
	end

	// element (r, c) of the square over the size in use
	function automatic logic signed [PV_W-1:0] square_entry(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		int     n;
		longint acc;
		n = (size_model > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(size_model);
		acc = 0;
		for (int k = 0; k < n; k++)
			acc += longint'(shadow_matrix[r][k]) * longint'(shadow_matrix[k][c]);
		return acc[PV_W-1:0];
	endfunction

	// index biased toward the part of the matrix in use
	function automatic logic [IDX_W-1:0] pick_index();
		int eff;
		eff = (size_model > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(size_model);
		if (eff > 0 && $urandom_range(0, 1) == 1)
			return IDX_W'($urandom_range(0, eff - 1));
		return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
	endfunction

	// result side: check each accepted result, then draw a stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (pending_squares.size() == 0) begin
				$error("unexpected result: row %0d col %0d product_value %0d",
					out_row, out_col, product_value);
				fail_count++;
			end else begin
				expected_entry = pending_squares.pop_front();
				if (product_value !== expected_entry.product) begin
					$error("product_value: expected %0d, actual %0d",
						expected_entry.product, product_value);
					fail_count++;
				end
				if (out_row !== expected_entry.row_idx) begin
					$error("out_row: expected %0d, actual %0d", expected_entry.row_idx, out_row);
					fail_count++;
				end
				if (out_col !== expected_entry.col_idx) begin
					$error("out_col: expected %0d, actual %0d", expected_entry.col_idx, out_col);
					fail_count++;
				end
			end
			stall_left = no_idle ? 0 : $urandom_range(0, 6);
		end else if (stall_left != 0) begin
			stall_left--;
		end
		out_stall <= (stall_left != 0);
	end

	// one request: idle gap, then hold until accepted, then update the shadow state
	task automatic send_request(input logic op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] v,
			input bit typed, input logic signed [PV_W-1:0] want);
		int            gap;
		square_entry_t e;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		row <= r;
		col <= c;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op == MODE_LOAD) begin
			shadow_matrix[r][c] = v;
			loads_sent++;
		end else begin
			e.product = typed ? want : square_entry(r, c);
			e.row_idx = r;
			e.col_idx = c;
			pending_squares.push_back(e);
			queries_sent++;
		end
	endtask

	// hold requests until every result is back and the back end has gone quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_squares.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] n);
		settle_block();
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_model = n;
		size_writes++;
	endtask

	task automatic add_step(input step_kind_t kind, input logic op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] v,
			input bit typed, input logic signed [PV_W-1:0] want);
		dir_step_t s;
		s.kind = kind;
		s.op = op;
		s.r = r;
		s.c = c;
		s.v = v;
		s.typed = typed;
		s.want = want;
		directed_steps.push_back(s);
	endtask

	// stimulus
	initial begin
		int                       phase_sizes [NUM_PHASES];
		dir_step_t                s;
		logic                     op;
		logic signed [ELEM_W-1:0] v;

		// directed table, walked after the whole store holds the most negative element
		add_step(STEP_REQ,  MODE_QUERY, 4'd0,  4'd0,  16'sh5a5a, 1'b1, 36'sd10737418240);
		add_step(STEP_REQ,  MODE_QUERY, 4'd15, 4'd15, 16'sh0000, 1'b1, 36'sd10737418240);
		add_step(STEP_SIZE, MODE_LOAD,  4'd0,  4'd0,  16'sd16,   1'b0, '0);
		add_step(STEP_REQ,  MODE_QUERY, 4'd5,  4'd9,  16'shffff, 1'b1, 36'sd17179869184);
		add_step(STEP_SIZE, MODE_LOAD,  4'd0,  4'd0,  16'sd0,    1'b0, '0);
		add_step(STEP_REQ,  MODE_QUERY, 4'd7,  4'd7,  16'sh0000, 1'b1, 36'sd0);
		add_step(STEP_REQ,  MODE_QUERY, 4'd15, 4'd0,  16'sh7fff, 1'b1, 36'sd0);
		add_step(STEP_SIZE, MODE_LOAD,  4'd0,  4'd0,  16'sd31,   1'b0, '0);
		add_step(STEP_REQ,  MODE_QUERY, 4'd15, 4'd0,  16'sh0000, 1'b1, 36'sd17179869184);
		add_step(STEP_REQ,  MODE_LOAD,  4'd0,  4'd0,  16'sh7fff, 1'b0, '0);
		add_step(STEP_REQ,  MODE_LOAD,  4'd0,  4'd1,  16'sh0000, 1'b0, '0);
		add_step(STEP_REQ,  MODE_LOAD,  4'd15, 4'd15, 16'sh0001, 1'b0, '0);
		add_step(STEP_REQ,  MODE_QUERY, 4'd0,  4'd0,  16'sh0000, 1'b0, '0);
		add_step(STEP_REQ,  MODE_QUERY, 4'd1,  4'd0,  16'sh0000, 1'b0, '0);
		add_step(STEP_REQ,  MODE_QUERY, 4'd15, 4'd15, 16'sh0000, 1'b0, '0);
		add_step(STEP_SIZE, MODE_LOAD,  4'd0,  4'd0,  16'sd1,    1'b0, '0);
		add_step(STEP_REQ,  MODE_QUERY, 4'd0,  4'd0,  16'sh0000, 1'b1, 36'sd1073676289);
		add_step(STEP_REQ,  MODE_QUERY, 4'd0,  4'd15, 16'sh0000, 1'b1, -36'sd1073709056);
		add_step(STEP_REQ,  MODE_QUERY, 4'd15, 4'd15, 16'sh0000, 1'b1, 36'sd1073741824);
		add_step(STEP_REQ,  MODE_LOAD,  4'd0,  4'd15, 16'sh7fff, 1'b0, '0);
		add_step(STEP_REQ,  MODE_QUERY, 4'd0,  4'd15, 16'sh0000, 1'b1, 36'sd1073676289);
		add_step(STEP_SIZE, MODE_LOAD,  4'd0,  4'd0,  16'sd10,   1'b0, '0);

		// reset
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write every entry before any query can read it
		for (int r = 0; r < MAX_DIM_DEF; r++)
			for (int c = 0; c < MAX_DIM_DEF; c++)
				send_request(MODE_LOAD, IDX_W'(r), IDX_W'(c), 16'sh8000, 1'b0, '0);

		// directed part
		foreach (directed_steps[i]) begin
			s = directed_steps[i];
			if (s.kind == STEP_SIZE)
				write_size(s.v[SIZE_W-1:0]);
			else
				send_request(s.op, s.r, s.c, s.v, s.typed, s.want);
		end

		// random part over several sizes, with some phases free of idling
		phase_sizes[0] = MAX_DIM_DEF;
		phase_sizes[1] = 1;
		phase_sizes[2] = $urandom_range(2, MAX_DIM_DEF - 1);
		phase_sizes[3] = $urandom_range(MAX_DIM_DEF + 1, 30);
		phase_sizes[4] = 31;
		phase_sizes[5] = SIZE_RESET;
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_size(SIZE_W'(phase_sizes[p]));
			no_idle = (p == 2 || p == 4);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// occasional full drain in the middle of a phase
				if ($urandom_range(0, 63) == 0)
					settle_block();
				op = ($urandom_range(0, 9) < 4) ? MODE_QUERY : MODE_LOAD;
				case ($urandom_range(0, 7))
					0: v = 16'sh8000;
					1: v = 16'sh7fff;
					default: v = ELEM_W'($urandom_range(0, 65535));
				endcase
				send_request(op, pick_index(), pick_index(), v, 1'b0, '0);
			end
		end
		no_idle = 1'b0;

		settle_block();
		$display("sent %0d loads and %0d queries over %0d size writes, sizes 0 to 31",
			loads_sent, queries_sent, size_writes);
		$display("compared %0d square entries, %0d field mismatches", results_checked, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
